// ===== hw/rtl/ordered_array_table_engine_defines.svh =====
// Assertion macros shared by the ordered table engine modules.
`ifndef ORDERED_ARRAY_TABLE_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define OATE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define OATE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/oate_pkg.sv =====
// Shared types, codes and defaults of the ordered table engine.
package oate_pkg;

    localparam int OATE_CAPACITY   = 64;
    localparam int OATE_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_SEARCH = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_UP,
        S_PUT,
        S_DOWN,
        S_SEARCH,
        S_READ,
        S_FINISH
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic    latch;
        logic    clear_count;
        logic    start_up;
        logic    step_up;
        logic    put;
        logic    start_dn;
        logic    step_dn;
        logic    count_dec;
        logic    start_srch;
        logic    step_srch;
        logic    hit_capture;
        logic    rd_issue;
        logic    rd_capture;
        logic    set_status;
        t_status status;
        logic    load_out;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic [2:0] act;
        logic       full;
        logic       pos_gt_count;
        logic       pos_ge_count;
        logic       up_more;
        logic       dn_more;
        logic       srch_hit;
        logic       srch_more;
    } t_dp_stat;

endpackage

// ===== hw/rtl/oate_cmd_if.sv =====
// Command channel: one table request per transfer.
interface oate_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [6:0]         position;
    logic signed [31:0] item_value;

    modport source (output valid, action, position, item_value, input ready);
    modport sink   (input valid, action, position, item_value, output ready);
endinterface

// ===== hw/rtl/oate_rsp_if.sv =====
// Response channel: one result per table request.
interface oate_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [5:0]         found_index;
    logic signed [31:0] read_data;
    logic [6:0]         entry_count;

    modport source (output valid, status, found_index, read_data, entry_count, input ready);
    modport sink   (input valid, status, found_index, read_data, entry_count, output ready);
endinterface

// ===== hw/rtl/oate_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module oate_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/oate_ctrl.sv =====
// Sequencer for table requests: decode, shift, scan, read and result hand-off.
module oate_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  oate_pkg::t_dp_stat i_stat,
    output oate_pkg::t_dp_cmd  o_cmd
);
    import oate_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.status = ST_OK;
        o_in_ready  = (r_state == S_IDLE);
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (t_action'(i_stat.act))
                    ACT_CLEAR: begin
                        o_cmd.clear_count = 1'b1;
                        n_state           = S_FINISH;
                    end
                    ACT_INSERT: begin
                        priority if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                            n_state          = S_FINISH;
                        end else if (i_stat.pos_gt_count) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                            n_state          = S_FINISH;
                        end else begin
                            o_cmd.start_up = 1'b1;
                            n_state        = S_UP;
                        end
                    end
                    ACT_DELETE: begin
                        if (i_stat.pos_ge_count) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                            n_state          = S_FINISH;
                        end else begin
                            o_cmd.start_dn = 1'b1;
                            n_state        = S_DOWN;
                        end
                    end
                    ACT_SEARCH: begin
                        // Assume a miss until a compare hits.
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_MISS;
                        o_cmd.start_srch = 1'b1;
                        n_state          = S_SEARCH;
                    end
                    ACT_READ: begin
                        if (i_stat.pos_ge_count) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                            n_state          = S_FINISH;
                        end else begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_READ;
                        end
                    end
                    default: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_RANGE;
                        n_state          = S_FINISH;
                    end
                endcase
            end
            S_UP: begin
                if (i_stat.up_more) begin
                    o_cmd.step_up = 1'b1;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_FINISH;
            end
            S_DOWN: begin
                if (i_stat.dn_more) begin
                    o_cmd.step_dn = 1'b1;
                end else begin
                    o_cmd.count_dec = 1'b1;
                    n_state         = S_FINISH;
                end
            end
            S_SEARCH: begin
                priority if (i_stat.srch_hit) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status      = ST_OK;
                    o_cmd.hit_capture = 1'b1;
                    n_state           = S_FINISH;
                end else if (i_stat.srch_more) begin
                    o_cmd.step_srch = 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_READ: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_FINISH;
            end
            S_FINISH: begin
                // Hold the result until the output slot is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

`include "ordered_array_table_engine_defines.svh"

    `OATE_ASSERT_NEXT(a_finish_loads, i_clk, i_rst_n,
        (r_state == S_FINISH) && (!r_out_valid || i_out_ready),
        r_out_valid && (r_state == S_IDLE), "finished result not presented")
    `OATE_ASSERT_NEXT(a_finish_holds, i_clk, i_rst_n,
        (r_state == S_FINISH) && r_out_valid && !i_out_ready,
        r_state == S_FINISH, "result dropped while output busy")
    `OATE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready,
        r_out_valid, "response withdrawn before acceptance")
endmodule

// ===== hw/rtl/oate_dp.sv =====
// Datapath: table memory, entry count, scan index and result registers.
module oate_dp #(
    parameter int CAPACITY   = oate_pkg::OATE_CAPACITY,
    parameter int DATA_WIDTH = oate_pkg::OATE_DATA_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  oate_pkg::t_dp_cmd  i_cmd,
    output oate_pkg::t_dp_stat o_stat,
    input  logic [2:0]         i_action,
    input  logic [6:0]         i_position,
    input  logic signed [31:0] i_item_value,
    output logic [1:0]         o_status,
    output logic [5:0]         o_found_index,
    output logic signed [31:0] o_read_data,
    output logic [6:0]         o_entry_count
);
    import oate_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 7) ? CW : 7;

    logic [2:0]            r_action;
    logic [6:0]            r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic                  r_pend;
    logic [AW-1:0]         r_wr_addr;
    logic                  r_chk;
    logic [AW-1:0]         r_cmp_idx;
    t_status               r_res_status;
    logic [5:0]            r_res_found;
    logic signed [31:0]    r_res_rdata;
    logic [1:0]            r_o_status;
    logic [5:0]            r_o_found;
    logic signed [31:0]    r_o_rdata;
    logic [6:0]            r_o_count;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic [XW-1:0]         w_pos_x;
    logic [XW-1:0]         w_cnt_x;

    // Each moved entry is written in the cycle after its read is issued.
    assign w_we    = r_pend || i_cmd.put;
    assign w_waddr = i_cmd.put ? AW'(r_pos) : r_wr_addr;
    assign w_wdata = i_cmd.put ? r_val : w_rdata;

    always_comb begin
        priority if (i_cmd.rd_issue) begin
            w_raddr = AW'(r_pos);
        end else if (i_cmd.step_up) begin
            w_raddr = AW'(r_idx - CW'(1));
        end else begin
            w_raddr = r_idx[AW-1:0];
        end
    end

    oate_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_pos_x = XW'(r_pos);
    assign w_cnt_x = XW'(r_count);

    always_comb begin
        o_stat.act          = r_action;
        o_stat.full         = (r_count == CW'(CAPACITY));
        o_stat.pos_gt_count = (w_pos_x > w_cnt_x);
        o_stat.pos_ge_count = (w_pos_x >= w_cnt_x);
        o_stat.up_more      = (XW'(r_idx) > w_pos_x);
        o_stat.dn_more      = (r_idx < r_count);
        o_stat.srch_hit     = r_chk && (w_rdata == r_val);
        o_stat.srch_more    = (r_idx < r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_chk   <= 1'b0;
        end else begin
            priority if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end
            r_pend <= i_cmd.step_up || i_cmd.step_dn;
            r_chk  <= i_cmd.step_srch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action     <= i_action;
            r_pos        <= i_position;
            r_val        <= DATA_WIDTH'(i_item_value);
            r_res_status <= ST_OK;
            r_res_found  <= '0;
            r_res_rdata  <= '0;
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.hit_capture) begin
            r_res_found <= 6'(r_cmp_idx);
        end
        if (i_cmd.rd_capture) begin
            r_res_rdata <= 32'(signed'(w_rdata));
        end
        priority if (i_cmd.start_up) begin
            r_idx <= r_count;
        end else if (i_cmd.step_up) begin
            r_idx     <= r_idx - CW'(1);
            r_wr_addr <= r_idx[AW-1:0];
        end else if (i_cmd.start_dn) begin
            r_idx <= CW'(r_pos) + CW'(1);
        end else if (i_cmd.step_dn) begin
            r_idx     <= r_idx + CW'(1);
            r_wr_addr <= AW'(r_idx - CW'(1));
        end else if (i_cmd.start_srch) begin
            r_idx <= '0;
        end else if (i_cmd.step_srch) begin
            r_idx     <= r_idx + CW'(1);
            r_cmp_idx <= r_idx[AW-1:0];
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_res_status;
            r_o_found  <= r_res_found;
            r_o_rdata  <= r_res_rdata;
            r_o_count  <= 7'(r_count);
        end
    end

    assign o_status      = r_o_status;
    assign o_found_index = r_o_found;
    assign o_read_data   = r_o_rdata;
    assign o_entry_count = r_o_count;

`include "ordered_array_table_engine_defines.svh"

    `OATE_ASSERT_SAME(a_one_write, i_clk, i_rst_n, i_cmd.put, !r_pend, "shift write collides with insert write")
    `OATE_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "entry count above capacity")
    `OATE_ASSERT_NEXT(a_put_count, i_clk, i_rst_n, i_cmd.put, r_count == $past(r_count) + CW'(1), "insert did not grow the count")
endmodule

// ===== hw/rtl/ordered_array_table_engine.sv =====
// Top level of the ordered table engine: controller, datapath and channel hookup.
// Keeps an ordered table of CAPACITY words in a single-port-write RAM plus an entry
// count, and serves one request at a time (clear, insert, delete, search, read),
// returning one response per request. The table RAM moves or compares one entry per
// cycle, so insert and delete time grows with the number of entries moved, and search
// time with the number of entries compared (up to the hit, or all of them on a miss).
// Responses go into an output register, so a new request is taken while the previous
// response waits; the engine stalls at the end of a request only if that register is
// still full. No clearing pass runs after reset; entries at or past the count are
// never read.
module ordered_array_table_engine #(
    parameter int CAPACITY   = oate_pkg::OATE_CAPACITY,
    parameter int DATA_WIDTH = oate_pkg::OATE_DATA_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    oate_cmd_if.sink     i_cmd,
    oate_rsp_if.source   o_rsp
);
    import oate_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;

    oate_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    oate_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_action      (i_cmd.action),
        .i_position    (i_cmd.position),
        .i_item_value  (i_cmd.item_value),
        .o_status      (o_rsp.status),
        .o_found_index (o_rsp.found_index),
        .o_read_data   (o_rsp.read_data),
        .o_entry_count (o_rsp.entry_count)
    );

    assign i_cmd.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;
endmodule

// ===== tb/tb_ordered_array_table_engine.sv =====
// Self-checking testbench for the ordered table engine: directed and random requests.
module tb_ordered_array_table_engine;
    import oate_pkg::*;

    localparam int TABLE_DEPTH   = OATE_CAPACITY;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_TAIL    = 80;
    localparam int CYCLE_LIMIT   = 800000;
    localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;
    localparam logic [6:0] POS_MAX          = 7'h7f;
    localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [31:0] VAL_NEG_ONE = 32'hffff_ffff;

    typedef struct packed {
        t_status     status;
        logic [5:0]  found_index;
        logic [31:0] read_data;
        logic [6:0]  entry_count;
    } table_rsp_t;

    typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_SELDOM, RDY_TOGGLE} ready_mode_e;

    logic i_clk = 1'b0;
    logic i_rst_n;

    oate_cmd_if cmd_bus ();
    oate_rsp_if rsp_bus ();

    ordered_array_table_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the table and its count, updated at each accepted request.
    logic [31:0] shadow_words [TABLE_DEPTH];
    int          shadow_count;
    table_rsp_t  pending_responses [$];

    int   error_count;
    int   rsp_seen;
    int   burst_left;
    bit   cmd_held;
    bit   back_to_back;
    int   hold_gen;
    int   hold_seen;
    int   hold_left;
    int   mode_left;
    ready_mode_e stall_mode;
    table_rsp_t  rsp_want;
    int   cycle_count;

    function automatic table_rsp_t predict_table_response(logic [2:0] act, logic [6:0] pos,
                                                          logic [31:0] val);
        table_rsp_t r;
        int i;
        bit hit;
        r = '{status: ST_OK, found_index: '0, read_data: '0, entry_count: '0};
        hit = 1'b0;
        case (act)
            ACT_CLEAR: shadow_count = 0;
            ACT_INSERT: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else if (int'(pos) > shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = shadow_count; i > int'(pos); i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[pos] = val;
                    shadow_count++;
                end
            end
            ACT_DELETE: begin
                if (int'(pos) >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = int'(pos); i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_count--;
                end
            end
            ACT_SEARCH: begin
                r.status = ST_MISS;
                for (i = 0; i < shadow_count; i++) begin
                    if (!hit && shadow_words[i] == val) begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.found_index = i[5:0];
                    end
                end
            end
            ACT_READ: begin
                if (int'(pos) >= shadow_count)
                    r.status = ST_RANGE;
                else
                    r.read_data = shadow_words[pos];
            end
            default: r.status = ST_RANGE;
        endcase
        r.entry_count = shadow_count[6:0];
        return r;
    endfunction

    // Small pool of values so that duplicates and extremes show up often.
    function automatic logic [31:0] pick_value();
        logic [31:0] pool [8];
        pool = '{VAL_MAX, VAL_MIN, 32'h0, VAL_NEG_ONE, 32'h1, 32'h5555_5555,
                 32'haaaa_aaaa, 32'h0000_8000};
        if ($urandom_range(0, 1) == 0)
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at response %0d: got %h expected %h",
                 field, rsp_seen, got, want);
        error_count++;
    endtask

    task automatic send_request(input logic [2:0] act, input logic [6:0] pos,
                                input logic [31:0] val);
        int gap;
        if (!cmd_held) begin
            gap = back_to_back ? 1 : $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.action     <= act;
        cmd_bus.position   <= pos;
        cmd_bus.item_value <= val;
        cmd_held = 1'b1;
        do @(posedge i_clk); while (!cmd_bus.ready);
        pending_responses.push_back(predict_table_response(act, pos, val));
        if (!back_to_back) begin
            if (burst_left == 0) begin
                // End the burst: drop valid until the next gap runs out.
                cmd_bus.valid <= 1'b0;
                cmd_held = 1'b0;
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                         : $urandom_range(0, 8);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_responses();
        if (cmd_held) begin
            cmd_bus.valid <= 1'b0;
            cmd_held = 1'b0;
        end
        while (pending_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        logic [2:0] act;
        send_request(ACT_READ, 7'd0, $urandom);
        send_request(ACT_DELETE, 7'd0, $urandom);
        send_request(ACT_SEARCH, 7'd0, 32'h0);
        send_request(ACT_INSERT, 7'd1, VAL_MAX);
        send_request(ACT_CLEAR, POS_MAX, VAL_NEG_ONE);
        for (act = ACT_FIRST_UNUSED; act != ACT_FIRST_UNUSED - 3'd1; act++) begin
            send_request(act, 7'd0, $urandom);
            if (act == ACT_LAST_UNUSED)
                break;
        end
    endtask

    task automatic test_extreme_values();
        int i;
        send_request(ACT_INSERT, 7'd0, VAL_MAX);
        send_request(ACT_INSERT, 7'd1, VAL_MIN);
        send_request(ACT_INSERT, 7'd0, 32'h0);
        send_request(ACT_INSERT, 7'd1, VAL_NEG_ONE);
        send_request(ACT_INSERT, 7'd5, $urandom);
        send_request(ACT_INSERT, POS_MAX, $urandom);
        for (i = 0; i <= 4; i++)
            send_request(ACT_READ, i[6:0], $urandom);
        send_request(ACT_READ, POS_MAX, $urandom);
        send_request(ACT_SEARCH, POS_MAX, VAL_MAX);
        send_request(ACT_SEARCH, 7'd0, VAL_MIN);
        send_request(ACT_SEARCH, 7'd0, VAL_NEG_ONE);
        send_request(ACT_SEARCH, 7'd0, 32'd12345);
        send_request(ACT_DELETE, POS_MAX, $urandom);
        send_request(ACT_DELETE, 7'd1, $urandom);
        send_request(ACT_DELETE, 7'd2, $urandom);
        send_request(ACT_READ, 7'd1, $urandom);
    endtask

    task automatic test_full_table();
        while (shadow_count < TABLE_DEPTH)
            send_request(ACT_INSERT, 7'($urandom_range(0, shadow_count)), pick_value());
        // Full takes priority over a bad position.
        send_request(ACT_INSERT, 7'(TABLE_DEPTH), $urandom);
        send_request(ACT_INSERT, POS_MAX, $urandom);
        send_request(ACT_INSERT, 7'd0, $urandom);
        send_request(ACT_READ, 7'(TABLE_DEPTH - 1), $urandom);
        send_request(ACT_READ, 7'(TABLE_DEPTH), $urandom);
        send_request(ACT_SEARCH, 7'd0, shadow_words[TABLE_DEPTH - 1]);
        send_request(ACT_DELETE, 7'(TABLE_DEPTH - 1), $urandom);
        send_request(ACT_INSERT, 7'(TABLE_DEPTH - 1), VAL_MIN);
        send_request(ACT_DELETE, 7'd0, $urandom);
        send_request(ACT_READ, 7'd0, $urandom);
    endtask

    task automatic test_clear_table();
        send_request(ACT_CLEAR, 7'd0, $urandom);
        send_request(ACT_READ, 7'd0, $urandom);
        send_request(ACT_DELETE, 7'd0, $urandom);
        send_request(ACT_SEARCH, 7'd0, VAL_MIN);
        send_request(ACT_INSERT, 7'd0, VAL_NEG_ONE);
        send_request(ACT_READ, 7'd0, $urandom);
        send_request(ACT_CLEAR, 7'd0, $urandom);
    endtask

    task automatic test_response_backpressure();
        int i;
        back_to_back = 1'b1;
        hold_gen++;
        for (i = 0; i < 16; i++) begin
            if (i % 4 == 3)
                send_request(ACT_SEARCH, 7'd0, pick_value());
            else
                send_request(ACT_INSERT, 7'($urandom_range(0, shadow_count)), pick_value());
        end
        back_to_back = 1'b0;
    endtask

    task automatic test_random_traffic();
        int n;
        int r;
        bit grow;
        logic [2:0] act;
        logic [6:0] pos;
        logic [31:0] val;
        grow = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (shadow_count == TABLE_DEPTH)
                grow = 1'b0;
            else if (shadow_count == 0 || $urandom_range(0, 149) == 0)
                grow = ~grow;
            r = $urandom_range(0, 99);
            pos = 7'($urandom_range(0, 127));
            val = $urandom;
            if ($urandom_range(0, 4) == 0) begin
                act = 3'($urandom_range(0, 7));
            end else begin
                if (r < 1)
                    act = ACT_CLEAR;
                else if (r < 4)
                    act = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
                else if (r < (grow ? 60 : 28))
                    act = ACT_INSERT;
                else if (r < (grow ? 70 : 52))
                    act = ACT_DELETE;
                else if (r < 85)
                    act = ACT_SEARCH;
                else
                    act = ACT_READ;
                case (act)
                    ACT_INSERT: begin
                        pos = 7'($urandom_range(0, shadow_count));
                        val = pick_value();
                    end
                    ACT_DELETE, ACT_READ: begin
                        if (shadow_count > 0)
                            pos = 7'($urandom_range(0, shadow_count - 1));
                    end
                    ACT_SEARCH: begin
                        if (shadow_count > 0 && $urandom_range(0, 9) < 7)
                            val = shadow_words[$urandom_range(0, shadow_count - 1)];
                        else
                            val = pick_value();
                    end
                    default: ;
                endcase
            end
            send_request(act, pos, val);
        end
    endtask

    // Response sink: random stall modes plus a long hold-off when the back-pressure test starts.
    initial begin
        rsp_bus.ready = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        mode_left = 0;
        stall_mode = RDY_ALWAYS;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_bus.ready <= 1'b0;
            end else begin
                if (hold_gen != hold_seen) begin
                    hold_seen = hold_gen;
                    hold_left = HOLD_CYCLES;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    rsp_bus.ready <= 1'b0;
                end else begin
                    if (mode_left == 0) begin
                        stall_mode = ready_mode_e'($urandom_range(0, 3));
                        mode_left = $urandom_range(16, 160);
                    end
                    mode_left--;
                    case (stall_mode)
                        RDY_ALWAYS: rsp_bus.ready <= 1'b1;
                        RDY_MOSTLY: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                        RDY_SELDOM: rsp_bus.ready <= ($urandom_range(0, 2) == 0);
                        default:    rsp_bus.ready <= ~rsp_bus.ready;
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response with nothing pending", 32'(rsp_bus.status), 32'h0);
            end else begin
                rsp_want = pending_responses.pop_front();
                if (rsp_bus.status !== rsp_want.status)
                    report_mismatch("status", 32'(rsp_bus.status), 32'(rsp_want.status));
                if (rsp_bus.found_index !== rsp_want.found_index)
                    report_mismatch("found_index", 32'(rsp_bus.found_index),
                                    32'(rsp_want.found_index));
                if (rsp_bus.read_data !== rsp_want.read_data)
                    report_mismatch("read_data", rsp_bus.read_data, rsp_want.read_data);
                if (rsp_bus.entry_count !== rsp_want.entry_count)
                    report_mismatch("entry_count", 32'(rsp_bus.entry_count),
                                    32'(rsp_want.entry_count));
            end
            rsp_seen++;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.action     = ACT_CLEAR;
        cmd_bus.position   = '0;
        cmd_bus.item_value = '0;
        error_count  = 0;
        rsp_seen     = 0;
        burst_left   = 0;
        cmd_held     = 1'b0;
        back_to_back = 1'b0;
        hold_gen     = 0;
        shadow_count = 0;
        foreach (shadow_words[i])
            shadow_words[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_extreme_values();
        test_full_table();
        test_clear_table();
        test_response_backpressure();
        test_random_traffic();

        wait_for_responses();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (error_count == 0 && pending_responses.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/oate_pkg.sv
hw/rtl/oate_cmd_if.sv
hw/rtl/oate_rsp_if.sv
hw/rtl/oate_ram.sv
hw/rtl/oate_ctrl.sv
hw/rtl/oate_dp.sv
hw/rtl/ordered_array_table_engine.sv
tb/tb_ordered_array_table_engine.sv
